@@ rtl/shsfp_pkg.sv @@
// Package for the signed hex sensor frame parser.
// Holds widths, character codes, register indexes and the character decoder.
// Used by signed_hex_sensor_frame_parser_unit; depends on nothing.
`default_nettype none

package shsfp_pkg;

  localparam int SensorCountDef    = 2;
  localparam int FrameBodyBytesDef = 34;

  localparam int ByteW  = 8;
  localparam int PosW   = 6;
  localparam int AccW   = 16;
  localparam int ValW   = 17;
  localparam int ChanW  = 2;
  localparam int CfgIdxW = 1;

  localparam logic [ByteW-1:0] CharNeg = 8'h6E;
  localparam logic [ByteW-1:0] CharPos = 8'h70;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartByte     = 1'b0,
    CfgAirflowEnable = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0] digit;
    logic       neg;
    logic       bad;
  } char_info_t;

  function automatic char_info_t decode_char(input logic [ByteW-1:0] ch);
    char_info_t info;
    info = '{digit: 4'd0, neg: 1'b0, bad: 1'b0};
    if (ch == CharNeg) begin
      info.neg = 1'b1;
    end else if (ch == CharPos) begin
      info.neg = 1'b0;
    end else if (ch inside {[8'h30:8'h39]}) begin
      info.digit = 4'(ch - 8'h30);
    end else if (ch inside {[8'h61:8'h66]}) begin
      info.digit = 4'(ch - 8'h57);
    end else if (ch inside {[8'h41:8'h46]}) begin
      info.digit = 4'(ch - 8'h37);
    end else begin
      info.bad = 1'b1;
    end
    return info;
  endfunction

endpackage

`default_nettype wire

@@ rtl/signed_hex_sensor_frame_parser_unit.sv @@
// Top level of the signed hex sensor frame parser.
// Uses shsfp_pkg for widths, character codes, register indexes and the decoder.
//
// Usage: received bytes enter on the rx channel (valid/ready, one byte per
// transaction). While idle the block waits for a byte equal to the start_byte
// register; the FRAME_BODY_BYTES bytes that follow are the frame body. Each
// 8-byte group of the body (four hex characters of current, then four of
// voltage) yields one transaction on the result channel, carrying the channel
// index, signed milli-unit values, valid flags and end-of-frame summary.
// No result is sent while airflow_enable is 0. Bytes past the groups are
// dropped. Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i;
// the user must write it only while the block is idle, which the block does not enforce.
// Timing: an accepted byte is held in the input register and decoded into the
// result register when that register is free, so a result is registered from
// the last byte of its group. Throughput is one byte per cycle while the result
// receiver does not stall, set by the single decode pass between the two registers.
// Reset clears the frame state, sets start_byte to 0 and airflow_enable to 1.
// When the result receiver stalls, the held result and any buffered byte stay
// in place; once a byte is buffered, rx_ready_o drops until the result is taken.
`default_nettype none

module signed_hex_sensor_frame_parser_unit #(
  parameter int SENSOR_COUNT     = shsfp_pkg::SensorCountDef,
  parameter int FRAME_BODY_BYTES = shsfp_pkg::FrameBodyBytesDef
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [shsfp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire [shsfp_pkg::ByteW-1:0]       cfg_wdata_i,
  input  wire                              rx_valid_i,
  output logic                             rx_ready_o,
  input  wire [shsfp_pkg::ByteW-1:0]       rx_byte_i,
  output logic                             res_valid_o,
  input  wire                              res_ready_i,
  output logic [shsfp_pkg::ChanW-1:0]      channel_o,
  output logic signed [shsfp_pkg::ValW-1:0] current_milli_o,
  output logic signed [shsfp_pkg::ValW-1:0] voltage_milli_o,
  output logic                             current_ok_o,
  output logic                             voltage_ok_o,
  output logic                             last_group_o,
  output logic                             frame_any_valid_o
);

  localparam int PosW  = shsfp_pkg::PosW;
  localparam int AccW  = shsfp_pkg::AccW;
  localparam int ValW  = shsfp_pkg::ValW;
  localparam int ByteW = shsfp_pkg::ByteW;
  localparam int GroupLimit = (2 * SENSOR_COUNT) < (FRAME_BODY_BYTES / 8) ?
                              (2 * SENSOR_COUNT) : (FRAME_BODY_BYTES / 8);

  logic [ByteW-1:0] start_byte_q;
  logic             airflow_en_q;

  logic             s1_valid_q, s1_valid_d;
  logic [ByteW-1:0] s1_byte_q;

  logic            in_frame_q, in_frame_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            neg_q, neg_d;
  logic            good_q, good_d;
  logic [ValW-1:0] held_q, held_d;
  logic            held_ok_q, held_ok_d;
  logic            any_q, any_d;

  logic                    out_valid_q, out_valid_d;
  logic [shsfp_pkg::ChanW-1:0] chan_q, chan_d;
  logic [ValW-1:0]         cur_q, cur_d;
  logic [ValW-1:0]         volt_q, volt_d;
  logic                    cur_ok_q, cur_ok_d;
  logic                    volt_ok_q, volt_ok_d;
  logic                    last_q, last_d;
  logic                    fav_q, fav_d;

  logic                  take;
  logic                  work;
  logic [2:0]            grp;
  logic [2:0]            chr;
  logic                  in_group;
  logic                  seg_start;
  shsfp_pkg::char_info_t info;
  logic [AccW-1:0]       acc_n;
  logic                  neg_n;
  logic                  good_n;
  logic [ValW-1:0]       val_n;
  logic                  v_ok;
  logic                  is_last;
  logic [PosW:0]         pos_inc;

  assign take       = !out_valid_q || res_ready_i;
  assign work       = s1_valid_q && take;
  assign rx_ready_o = !s1_valid_q || take;

  always_comb begin
    grp       = pos_q[PosW-1:3];
    chr       = pos_q[2:0];
    in_group  = grp < 3'(GroupLimit);
    seg_start = (chr[1:0] == 2'd0);
    info      = shsfp_pkg::decode_char(s1_byte_q);
    acc_n     = {(seg_start ? 12'd0 : acc_q[11:0]), info.digit};
    neg_n     = (seg_start ? 1'b0 : neg_q) | info.neg;
    good_n    = (seg_start ? 1'b1 : good_q) & !info.bad;
    val_n     = neg_n ? (ValW'(0) - {1'b0, acc_n}) : {1'b0, acc_n};
    v_ok      = held_ok_q && good_n;
    is_last   = (grp == 3'(GroupLimit - 1));
    pos_inc   = {1'b0, pos_q} + (PosW + 1)'(1);

    s1_valid_d = rx_ready_o ? rx_valid_i : s1_valid_q;
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    good_d     = good_q;
    held_d     = held_q;
    held_ok_d  = held_ok_q;
    any_d      = any_q;

    out_valid_d = take ? 1'b0 : out_valid_q;
    chan_d      = chan_q;
    cur_d       = cur_q;
    volt_d      = volt_q;
    cur_ok_d    = cur_ok_q;
    volt_ok_d   = volt_ok_q;
    last_d      = last_q;
    fav_d       = fav_q;

    if (work) begin
      if (!in_frame_q) begin
        if (s1_byte_q == start_byte_q) begin
          in_frame_d = 1'b1;
          pos_d      = '0;
          any_d      = 1'b0;
        end
      end else begin
        if (in_group) begin
          acc_d  = acc_n;
          neg_d  = neg_n;
          good_d = good_n;
          if (chr == 3'd3) begin
            held_ok_d = good_n;
            held_d    = good_n ? val_n : '0;
          end else if (chr == 3'd7) begin
            any_d       = any_q | v_ok;
            out_valid_d = airflow_en_q;
            chan_d      = grp[1:0];
            cur_d       = held_q;
            volt_d      = v_ok ? val_n : '0;
            cur_ok_d    = held_ok_q;
            volt_ok_d   = v_ok;
            last_d      = is_last;
            fav_d       = is_last && (any_q | v_ok);
          end
        end
        if (pos_inc >= (PosW + 1)'(FRAME_BODY_BYTES)) begin
          in_frame_d = 1'b0;
          pos_d      = '0;
        end else begin
          pos_d = pos_inc[PosW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= '0;
      airflow_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (shsfp_pkg::cfg_idx_e'(cfg_idx_i))
        shsfp_pkg::CfgStartByte:     start_byte_q <= cfg_wdata_i;
        shsfp_pkg::CfgAirflowEnable: airflow_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      in_frame_q  <= 1'b0;
      pos_q       <= '0;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      good_q      <= 1'b1;
      held_q      <= '0;
      held_ok_q   <= 1'b0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      in_frame_q  <= in_frame_d;
      pos_q       <= pos_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      good_q      <= good_d;
      held_q      <= held_d;
      held_ok_q   <= held_ok_d;
      any_q       <= any_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_ready_o) begin
      s1_byte_q <= rx_byte_i;
    end
    chan_q    <= chan_d;
    cur_q     <= cur_d;
    volt_q    <= volt_d;
    cur_ok_q  <= cur_ok_d;
    volt_ok_q <= volt_ok_d;
    last_q    <= last_d;
    fav_q     <= fav_d;
  end

  assign res_valid_o       = out_valid_q;
  assign channel_o         = chan_q;
  assign current_milli_o   = cur_q;
  assign voltage_milli_o   = volt_q;
  assign current_ok_o      = cur_ok_q;
  assign voltage_ok_o      = volt_ok_q;
  assign last_group_o      = last_q;
  assign frame_any_valid_o = fav_q;

  a_volt_needs_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (!voltage_ok_o || current_ok_o))
    else $error("voltage_ok set without current_ok");

  a_any_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (!frame_any_valid_o || (last_group_o && voltage_ok_o) ||
                     last_group_o))
    else $error("frame_any_valid set on a group that is not last");

  a_bad_cur_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !current_ok_o) |-> (current_milli_o == '0))
    else $error("bad current carries a nonzero value");

  a_pos_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q < PosW'(FRAME_BODY_BYTES)) && (in_frame_q || (pos_q == '0)))
    else $error("frame position out of range");

  a_emit_at_group_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !$past(res_valid_o)) |-> ($past(chr) == 3'd7))
    else $error("result appeared away from the end of a group");

endmodule

`default_nettype wire

@@ bench/sensor_frame_check_pkg.sv @@
// Scoreboard for the signed hex sensor frame parser bench: a byte-level predictor of the
// parser and an in-order store of the group results it expects.
// Depends on shsfp_pkg for widths, sign characters and register indexes.
`default_nettype none

package sensor_frame_check_pkg;
  import shsfp_pkg::*;

  localparam int BodyBytes  = FrameBodyBytesDef;
  localparam int GroupCount = ((2 * SensorCountDef) < (BodyBytes / 8)) ?
                              (2 * SensorCountDef) : (BodyBytes / 8);

  typedef struct {
    logic [ChanW-1:0]       channel;
    logic signed [ValW-1:0] current_milli;
    logic signed [ValW-1:0] voltage_milli;
    logic                   current_ok;
    logic                   voltage_ok;
    logic                   last_group;
    logic                   frame_any_valid;
  } group_result_t;

  class sensor_frame_scoreboard;
    logic [ByteW-1:0]       start_byte = '0;
    logic                   airflow_on = 1'b1;
    logic [PosW-1:0]        body_pos = '0;
    logic                   framing = 1'b0;
    logic [AccW-1:0]        digits = '0;
    logic                   negative = 1'b0;
    logic                   chars_ok = 1'b1;
    logic signed [ValW-1:0] current_hold = '0;
    logic                   current_hold_ok = 1'b0;
    logic                   any_voltage_ok = 1'b0;
    group_result_t          expected_groups[$];
    int                     mismatches = 0;

    function void set_register(cfg_idx_e idx, logic [ByteW-1:0] value);
      if (idx == CfgStartByte) begin
        start_byte = value;
      end else begin
        airflow_on = value[0];
      end
    endfunction

    function logic signed [ValW-1:0] milli_value();
      logic signed [ValW-1:0] mag;
      mag = {1'b0, digits};
      return negative ? -mag : mag;
    endfunction

    function void shift_char(logic [ByteW-1:0] ch);
      logic [3:0] digit;
      digit = 4'd0;
      if (ch == CharNeg) begin
        negative = 1'b1;
      end else if (ch == CharPos) begin
        digit = 4'd0;
      end else if (ch >= "0" && ch <= "9") begin
        digit = 4'(ch - "0");
      end else if (ch >= "a" && ch <= "f") begin
        digit = 4'(ch - "a" + 10);
      end else if (ch >= "A" && ch <= "F") begin
        digit = 4'(ch - "A" + 10);
      end else begin
        chars_ok = 1'b0;
      end
      digits = {digits[AccW-5:0], digit};
    endfunction

    function void note_byte(logic [ByteW-1:0] ch);
      int grp;
      int slot;
      group_result_t r;
      if (!framing) begin
        if (ch == start_byte) begin
          framing = 1'b1;
          body_pos = '0;
          any_voltage_ok = 1'b0;
        end
        return;
      end
      grp = int'(body_pos) / 8;
      slot = int'(body_pos) % 8;
      if (grp < GroupCount) begin
        if (slot == 0 || slot == 4) begin
          digits = '0;
          negative = 1'b0;
          chars_ok = 1'b1;
        end
        shift_char(ch);
        if (slot == 3) begin
          current_hold_ok = chars_ok;
          current_hold = chars_ok ? milli_value() : '0;
        end else if (slot == 7) begin
          r.channel = ChanW'(grp);
          r.current_milli = current_hold;
          r.current_ok = current_hold_ok;
          r.voltage_ok = current_hold_ok && chars_ok;
          r.voltage_milli = r.voltage_ok ? milli_value() : '0;
          r.last_group = (grp == GroupCount - 1);
          if (r.voltage_ok) begin
            any_voltage_ok = 1'b1;
          end
          r.frame_any_valid = r.last_group && any_voltage_ok;
          if (airflow_on) begin
            expected_groups.push_back(r);
          end
        end
      end
      if (int'(body_pos) + 1 >= BodyBytes) begin
        framing = 1'b0;
        body_pos = '0;
      end else begin
        body_pos = body_pos + PosW'(1);
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(group_result_t got);
      group_result_t want;
      if (expected_groups.size() == 0) begin
        $error("unexpected result for channel %0d", got.channel);
        mismatches++;
        return;
      end
      want = expected_groups.pop_front();
      compare_field("channel", want.channel, got.channel);
      compare_field("current_milli", want.current_milli, got.current_milli);
      compare_field("voltage_milli", want.voltage_milli, got.voltage_milli);
      compare_field("current_ok", want.current_ok, got.current_ok);
      compare_field("voltage_ok", want.voltage_ok, got.voltage_ok);
      compare_field("last_group", want.last_group, got.last_group);
      compare_field("frame_any_valid", want.frame_any_valid, got.frame_any_valid);
    endfunction

    function int outstanding();
      return expected_groups.size();
    endfunction
  endclass

endpackage

`default_nettype wire

@@ bench/tb_top.sv @@
// Top-level bench for signed_hex_sensor_frame_parser_unit: drives byte streams of framed and
// noisy data, stalls both channels at random and checks every group result in order.
// Depends on shsfp_pkg and sensor_frame_check_pkg.
`default_nettype none

module tb_top;
  import shsfp_pkg::*;
  import sensor_frame_check_pkg::*;

  localparam int CycleLimit = 400000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx = '0;
  logic [ByteW-1:0]       cfg_wdata = '0;
  logic                   rx_valid = 1'b0;
  logic                   rx_ready;
  logic [ByteW-1:0]       rx_byte = '0;
  logic                   res_valid;
  logic                   res_ready = 1'b0;
  logic [ChanW-1:0]       channel;
  logic signed [ValW-1:0] current_milli;
  logic signed [ValW-1:0] voltage_milli;
  logic                   current_ok;
  logic                   voltage_ok;
  logic                   last_group;
  logic                   frame_any_valid;

  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  int   hold_cycles = 0;
  int   cycles = 0;

  sensor_frame_scoreboard sb = new();

  signed_hex_sensor_frame_parser_unit uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .rx_valid_i        (rx_valid),
    .rx_ready_o        (rx_ready),
    .rx_byte_i         (rx_byte),
    .res_valid_o       (res_valid),
    .res_ready_i       (res_ready),
    .channel_o         (channel),
    .current_milli_o   (current_milli),
    .voltage_milli_o   (voltage_milli),
    .current_ok_o      (current_ok),
    .voltage_ok_o      (voltage_ok),
    .last_group_o      (last_group),
    .frame_any_valid_o (frame_any_valid)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_byte(logic [ByteW-1:0] value);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      rx_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_valid = 1'b1;
    rx_byte = value;
    do @(posedge clk); while (!rx_ready);
    sb.note_byte(value);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  task automatic drain();
    rx_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [ByteW-1:0] value);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_register(idx, value);
  endtask

  function automatic logic [ByteW-1:0] rand_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return "0" + ByteW'($urandom_range(0, 9));
    if (r < 55) return "a" + ByteW'($urandom_range(0, 5));
    if (r < 75) return "A" + ByteW'($urandom_range(0, 5));
    if (r < 84) return CharNeg;
    if (r < 92) return CharPos;
    return ByteW'($urandom_range(0, 255));
  endfunction

  task automatic send_frames(int count);
    logic junk;
    for (int f = 0; f < count; f++) begin
      repeat ($urandom_range(0, 3)) send_byte(ByteW'($urandom_range(0, 255)));
      send_byte(sb.start_byte);
      junk = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < BodyBytes; i++) begin
        if (junk || i >= GroupCount * 8) begin
          send_byte(ByteW'($urandom_range(0, 255)));
        end else begin
          send_byte(rand_char());
        end
      end
    end
  endtask

  initial begin
    int k;
    wait (rst_n);
    @(negedge clk);
    forever begin
      k = rx_steady ? 0 : $urandom_range(0, 3);
      if (hold_cycles > 0) begin
        k = hold_cycles;
        hold_cycles = 0;
      end
      if (k > 0) begin
        res_ready = 1'b0;
        repeat (k) @(negedge clk);
      end
      res_ready = 1'b1;
      do @(posedge clk); while (!res_valid);
      sb.check_result('{channel, current_milli, voltage_milli, current_ok, voltage_ok,
                        last_group, frame_any_valid});
      @(negedge clk);
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // A start byte of zero also appears inside the body, where it must count as a bad character.
    send_text("x");
    send_byte(sb.start_byte);
    send_text("FFFFffff");
    send_text("FFFnpn0A");
    send_text("12G40000");
    send_text("000012");
    send_byte(sb.start_byte);
    send_text("4zq");
    drain();

    write_reg(CfgStartByte, "$");
    write_reg(CfgAirflowEnable, 8'd1);
    send_frames(15);
    drain();

    write_reg(CfgStartByte, 8'hFF);
    write_reg(CfgAirflowEnable, 8'd0);
    send_frames(8);
    drain();

    write_reg(CfgStartByte, ":");
    write_reg(CfgAirflowEnable, 8'd1);
    hold_cycles = 80;
    send_frames(6);
    drain();
    hold_cycles = 120;
    send_frames(6);
    drain();

    write_reg(CfgStartByte, ByteW'($urandom_range(0, 255)));
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    send_frames(8);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    send_frames(12);
    drain();

    write_reg(CfgStartByte, 8'hFF);
    send_frames(5);
    drain();
    repeat (8) @(negedge clk);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/shsfp_pkg.sv
rtl/signed_hex_sensor_frame_parser_unit.sv
bench/sensor_frame_check_pkg.sv
bench/tb_top.sv
